// ----- hdl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and codes of the serial frame receiver
// Command, event and register codes, reset values and the result word type.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

  // Input commands
  localparam logic [1:0] CMD_BYTE     = 2'd0;
  localparam logic [1:0] CMD_TICK     = 2'd1;
  localparam logic [1:0] CMD_ACK_READ = 2'd2;
  localparam logic [1:0] CMD_NONE     = 2'd3;

  // Event kinds reported on the result channel
  localparam logic [3:0] EV_PAYLOAD  = 4'd0;
  localparam logic [3:0] EV_OK       = 4'd1;
  localparam logic [3:0] EV_CRC_ERR  = 4'd2;
  localparam logic [3:0] EV_ACK      = 4'd3;
  localparam logic [3:0] EV_SPURIOUS = 4'd4;
  localparam logic [3:0] EV_LOST     = 4'd5;
  localparam logic [3:0] EV_BUSY     = 4'd6;
  localparam logic [3:0] EV_IDLE     = 4'd7;
  localparam logic [3:0] EV_ACK_READ = 4'd8;

  // Configuration register indexes
  localparam logic REG_CRC_POLY   = 1'b0;
  localparam logic REG_IDLE_LIMIT = 1'b1;

  // Reset values and line codes
  localparam logic [15:0] CRC_POLY_RESET   = 16'h1021;
  localparam logic [7:0]  IDLE_LIMIT_RESET = 8'd3;
  localparam logic [7:0]  BYTE_ACK         = 8'h06;
  localparam logic [7:0]  BYTE_START_MIN   = 8'h01;
  localparam logic [7:0]  BYTE_START_MAX   = 8'h04;
  localparam int          COUNTER_WIDTH_DEFAULT = 16;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  data;
    logic [1:0]  prio;
    logic [7:0]  acks;
    logic [15:0] crc_err;
    logic [15:0] spurious;
    logic [15:0] lost;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/sfr_crc_byte.sv -----
// ----------------------------------------------------------------------------
// sfr_crc_byte: one-byte CRC-16 update
// Folds one byte into an MSB-first CRC-16 with a programmable polynomial.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_crc_byte (
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data,
  input  wire logic [15:0] poly,
  output logic      [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

// ----- hdl/sfr_engine.sv -----
// ----------------------------------------------------------------------------
// sfr_engine: frame parser state and event generation
// Holds the receive phase, length, CRC and counters, and forms a result
// word for every processed input word that raises an event.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_engine #(
  parameter int COUNTER_WIDTH = sfr_pkg::COUNTER_WIDTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  byte_value,
  input  wire logic [15:0] crc_poly,
  input  wire logic [7:0]  idle_limit,
  output logic             emit,
  output sfr_pkg::result_t result
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_LEN2 = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CRC1 = 3'd4;
  localparam logic [2:0] PH_CRC2 = 3'd5;

  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

  logic [2:0]               phase, phase_next;
  logic [14:0]              remaining, remaining_next;
  logic [15:0]              crc, crc_next;
  logic [7:0]               idle_ticks, idle_ticks_next;
  logic [1:0]               prio, prio_next;
  logic [7:0]               acks, acks_next;
  logic [COUNTER_WIDTH-1:0] bad_crc, bad_crc_next;
  logic [COUNTER_WIDTH-1:0] spurious, spurious_next;
  logic [COUNTER_WIDTH-1:0] lost, lost_next;

  logic [15:0] crc_folded;
  logic [15:0] crc_remainder;
  logic [8:0]  tick_count;
  logic [3:0]  kind;
  logic [7:0]  res_data;
  logic [7:0]  res_acks;

  sfr_crc_byte u_crc (
    .crc_in  (crc),
    .data    (byte_value),
    .poly    (crc_poly),
    .crc_out (crc_folded)
  );

  assign crc_remainder = crc ^ {8'h00, byte_value};
  assign tick_count    = {1'b0, idle_ticks} + 9'd1;

  always_comb begin
    phase_next      = phase;
    remaining_next  = remaining;
    crc_next        = crc;
    idle_ticks_next = idle_ticks;
    prio_next       = prio;
    acks_next       = acks;
    bad_crc_next    = bad_crc;
    spurious_next   = spurious;
    lost_next       = lost;
    emit            = 1'b0;
    kind            = sfr_pkg::EV_PAYLOAD;
    res_data        = 8'h00;
    res_acks        = acks;

    unique case (cmd)
      sfr_pkg::CMD_BYTE: begin
        idle_ticks_next = 8'd0;
        unique case (phase)
          PH_LEN: begin
            if (byte_value[7]) begin
              remaining_next = {byte_value[6:0], 8'h00};
              phase_next     = PH_LEN2;
            end else begin
              remaining_next = {7'd0, byte_value};
              phase_next     = (byte_value != 8'h00) ? PH_DATA : PH_CRC1;
            end
          end
          PH_LEN2: begin
            remaining_next = {remaining[14:8], byte_value};
            phase_next = ({remaining[14:8], byte_value} != 15'd0) ? PH_DATA : PH_CRC1;
          end
          PH_DATA: begin
            crc_next = crc_folded;
            if (remaining <= 15'd1) begin
              remaining_next = 15'd0;
              phase_next     = PH_CRC1;
            end else begin
              remaining_next = remaining - 15'd1;
            end
            emit     = 1'b1;
            kind     = sfr_pkg::EV_PAYLOAD;
            res_data = byte_value;
          end
          PH_CRC1: begin
            crc_next   = crc ^ {byte_value, 8'h00};
            phase_next = PH_CRC2;
          end
          PH_CRC2: begin
            emit = 1'b1;
            if (crc_remainder != 16'h0000) begin
              kind         = sfr_pkg::EV_CRC_ERR;
              bad_crc_next = (bad_crc == CNT_MAX) ? bad_crc : bad_crc + 1'b1;
            end else begin
              kind = sfr_pkg::EV_OK;
            end
            crc_next   = 16'h0000;
            phase_next = PH_IDLE;
          end
          default: begin
            // Idle, and the unused phase codes, which behave as idle.
            phase_next = PH_IDLE;
            if (byte_value == sfr_pkg::BYTE_ACK) begin
              acks_next = (acks == 8'hFF) ? acks : acks + 8'd1;
              res_acks  = acks_next;
              emit      = 1'b1;
              kind      = sfr_pkg::EV_ACK;
            end else if (byte_value >= sfr_pkg::BYTE_START_MIN &&
                         byte_value <= sfr_pkg::BYTE_START_MAX) begin
              prio_next  = 2'(byte_value - 8'd1);
              crc_next   = 16'h0000;
              phase_next = PH_LEN;
            end else begin
              spurious_next = (spurious == CNT_MAX) ? spurious : spurious + 1'b1;
              emit          = 1'b1;
              kind          = sfr_pkg::EV_SPURIOUS;
            end
          end
        endcase
      end
      sfr_pkg::CMD_TICK: begin
        emit = 1'b1;
        if (phase != PH_IDLE) begin
          if (tick_count > {1'b0, idle_limit}) begin
            idle_ticks_next = 8'd0;
            lost_next       = (lost == CNT_MAX) ? lost : lost + 1'b1;
            phase_next      = PH_IDLE;
            crc_next        = 16'h0000;
            remaining_next  = 15'd0;
            kind            = sfr_pkg::EV_LOST;
          end else begin
            idle_ticks_next = tick_count[7:0];
            kind            = sfr_pkg::EV_BUSY;
          end
        end else begin
          idle_ticks_next = 8'd0;
          kind            = sfr_pkg::EV_IDLE;
        end
      end
      sfr_pkg::CMD_ACK_READ: begin
        acks_next = 8'd0;
        emit      = 1'b1;
        kind      = sfr_pkg::EV_ACK_READ;
        res_acks  = acks;
      end
      sfr_pkg::CMD_NONE: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    result.kind     = kind;
    result.data     = res_data;
    result.prio     = prio_next;
    result.acks     = res_acks;
    result.crc_err  = 16'(bad_crc_next);
    result.spurious = 16'(spurious_next);
    result.lost     = 16'(lost_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      remaining  <= 15'd0;
      crc        <= 16'h0000;
      idle_ticks <= 8'd0;
      prio       <= 2'd0;
      acks       <= 8'd0;
      bad_crc    <= '0;
      spurious   <= '0;
      lost       <= '0;
    end else if (step) begin
      phase      <= phase_next;
      remaining  <= remaining_next;
      crc        <= crc_next;
      idle_ticks <= idle_ticks_next;
      prio       <= prio_next;
      acks       <= acks_next;
      bad_crc    <= bad_crc_next;
      spurious   <= spurious_next;
      lost       <= lost_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/serial_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// serial_frame_receiver: length-prefixed serial frame receiver with CRC-16
// Parses a received byte stream into acknowledges, framed payload and
// CRC-checked frame ends, with an idle-tick timeout and saturating counters.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   in      | input     | in_valid / in_ready  | cmd, byte_value
//   out     | output    | out_valid / out_ready| event_kind .. lost_count
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Every word is captured in the input register, parsed in one pass through
// the frame engine and the byte-wide CRC, and its event, if it has one, is
// written into the result register.
// Sustained rate is one word per cycle while out_ready stays high.
// A stalled result holds the result register; the input register then fills
// and in_ready drops until the result is taken.
// Reset clears the parser state, the counters and both valid flags, and loads
// the default polynomial and idle limit. The configuration port never stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_receiver #(
  parameter int COUNTER_WIDTH = sfr_pkg::COUNTER_WIDTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input word channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  byte_value,
  // Result word channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       event_kind,
  output logic [7:0]       data_byte,
  output logic [1:0]       frame_priority,
  output logic [7:0]       ack_count,
  output logic [15:0]      crc_error_count,
  output logic [15:0]      spurious_count,
  output logic [15:0]      lost_count,
  // Configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Configuration registers.
  logic [15:0] crc_poly;
  logic [7:0]  idle_limit;

  // Input register holding the word under work.
  logic        in_full;
  logic [1:0]  in_cmd;
  logic [7:0]  in_byte;

  // Result register.
  logic             res_full;
  sfr_pkg::result_t res;

  logic             advance;
  logic             emit;
  sfr_pkg::result_t engine_result;

  // The held word moves on whenever the result register is free or is being
  // emptied in this same cycle. Words that produce no event still wait for
  // that, which keeps the ordering simple.
  assign advance  = in_full && (!res_full || out_ready);
  assign in_ready = !in_full || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_poly   <= sfr_pkg::CRC_POLY_RESET;
      idle_limit <= sfr_pkg::IDLE_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sfr_pkg::REG_CRC_POLY:   crc_poly   <= cfg_data;
        sfr_pkg::REG_IDLE_LIMIT: idle_limit <= cfg_data[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_cmd  <= cmd;
      in_byte <= byte_value;
    end
  end

  sfr_engine #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .cmd        (in_cmd),
    .byte_value (in_byte),
    .crc_poly   (crc_poly),
    .idle_limit (idle_limit),
    .emit       (emit),
    .result     (engine_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (advance && emit) begin
      res_full <= 1'b1;
    end else if (out_ready) begin
      res_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res <= engine_result;
    end
  end

  assign out_valid       = res_full;
  assign event_kind      = res.kind;
  assign data_byte       = res.data;
  assign frame_priority  = res.prio;
  assign ack_count       = res.acks;
  assign crc_error_count = res.crc_err;
  assign spurious_count  = res.spurious;
  assign lost_count      = res.lost;

`ifndef SYNTH
  // Input side stalls only behind a full, blocked result register.
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (in_full && res_full && !out_ready))
    else $error("in_ready low without a blocked result");

  // A processed word with an event always shows up on the result channel.
  assert property (@(posedge clk) disable iff (rst)
    (advance && emit) |=> res_full)
    else $error("event lost between engine and result register");

  // A held word is never dropped without being processed.
  assert property (@(posedge clk) disable iff (rst)
    (in_full && !advance) |=> in_full)
    else $error("held input word dropped");

  // Only payload events carry a data byte.
  assert property (@(posedge clk) disable iff (rst)
    (res_full && event_kind != sfr_pkg::EV_PAYLOAD) |-> (data_byte == 8'h00))
    else $error("data byte set on a non-payload event");
`endif

endmodule

`default_nettype wire

// ----- verif/serial_frame_receiver_tb.sv -----
// ----------------------------------------------------------------------------
// serial_frame_receiver_tb: self-checking testbench of the serial frame receiver
// Drives command words (received bytes, idle ticks, acknowledge reads) with
// random idling on both channels. A cycle-free model of the frame parser
// predicts every result word, and a monitor compares each accepted result
// with the oldest prediction. Directed frames come first, then random
// framed traffic under several polynomial and idle-limit settings.
// ----------------------------------------------------------------------------
module serial_frame_receiver_tb;

  // Cycles of silence on every channel before the run is declared hung. The
  // longest legal silence is the deliberate receiver hold plus a few bursts.
  localparam int WATCHDOG_LIMIT = 2000;
  // Length of the deliberate receiver hold that fills the block.
  localparam int LONG_HOLD = 150;
  // Input register plus result register, with some margin.
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_LIMIT = 10;

  // Parser phases of the prediction model.
  localparam logic [2:0] S_HUNT   = 3'd0;
  localparam logic [2:0] S_LEN    = 3'd1;
  localparam logic [2:0] S_LEN_LO = 3'd2;
  localparam logic [2:0] S_DATA   = 3'd3;
  localparam logic [2:0] S_CRC_HI = 3'd4;
  localparam logic [2:0] S_CRC_LO = 3'd5;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = sfr_pkg::CMD_NONE;
  logic [7:0]  byte_value = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  event_kind;
  logic [7:0]  data_byte;
  logic [1:0]  frame_priority;
  logic [7:0]  ack_count;
  logic [15:0] crc_error_count;
  logic [15:0] spurious_count;
  logic [15:0] lost_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = sfr_pkg::REG_CRC_POLY;
  logic [15:0] cfg_data = 16'h0000;

  // Test control shared between the stimulus and the receiver process.
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int stall_left = 0;

  int words_sent = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  // Prediction model state: configuration copy and parser state.
  logic [15:0] m_poly;
  logic [7:0]  m_limit;
  logic [2:0]  m_phase;
  logic [14:0] m_remaining;
  logic [15:0] m_crc;
  logic [7:0]  m_ticks;
  logic [1:0]  m_prio;
  logic [7:0]  m_acks;
  logic [15:0] m_bad;
  logic [15:0] m_spur;
  logic [15:0] m_lost;

  // Result words predicted but not yet seen on the output, oldest first.
  sfr_pkg::result_t expected_events[$];

  serial_frame_receiver u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .byte_value      (byte_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .event_kind      (event_kind),
    .data_byte       (data_byte),
    .frame_priority  (frame_priority),
    .ack_count       (ack_count),
    .crc_error_count (crc_error_count),
    .spurious_count  (spurious_count),
    .lost_count      (lost_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction model
  // --------------------------------------------------------------------------

  // One byte folded into an MSB-first CRC-16.
  function automatic logic [15:0] crc16_fold_byte(input logic [15:0] crc,
                                                  input logic [7:0] b,
                                                  input logic [15:0] poly);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ poly) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  task automatic frame_model_reset();
    m_poly = sfr_pkg::CRC_POLY_RESET;
    m_limit = sfr_pkg::IDLE_LIMIT_RESET;
    m_phase = S_HUNT;
    m_remaining = '0;
    m_crc = '0;
    m_ticks = '0;
    m_prio = '0;
    m_acks = '0;
    m_bad = '0;
    m_spur = '0;
    m_lost = '0;
  endtask

  // Advances the model by one accepted word and queues the result word, if
  // the word causes one. Counters in the result are taken after the update.
  task automatic predict_events(input logic [1:0] c, input logic [7:0] b);
    sfr_pkg::result_t r;
    bit               emits;
    logic [15:0]      rem;
    int               n;
    r = '0;
    emits = 1'b0;
    case (c)
      sfr_pkg::CMD_BYTE: begin
        // Any received byte breaks a run of idle ticks.
        m_ticks = '0;
        case (m_phase)
          S_LEN: begin
            if (b[7]) begin
              m_remaining = {b[6:0], 8'h00};
              m_phase = S_LEN_LO;
            end else begin
              m_remaining = {7'd0, b};
              m_phase = (b != 8'h00) ? S_DATA : S_CRC_HI;
            end
          end
          S_LEN_LO: begin
            m_remaining = m_remaining | {7'd0, b};
            m_phase = (m_remaining != '0) ? S_DATA : S_CRC_HI;
          end
          S_DATA: begin
            m_crc = crc16_fold_byte(m_crc, b, m_poly);
            if (m_remaining <= 15'd1) begin
              m_remaining = '0;
              m_phase = S_CRC_HI;
            end else begin
              m_remaining = m_remaining - 15'd1;
            end
            r.kind = sfr_pkg::EV_PAYLOAD;
            r.data = b;
            emits = 1'b1;
          end
          S_CRC_HI: begin
            m_crc = m_crc ^ {b, 8'h00};
            m_phase = S_CRC_LO;
          end
          S_CRC_LO: begin
            rem = m_crc ^ {8'h00, b};
            if (rem != '0) begin
              m_bad = sat_inc(m_bad);
              r.kind = sfr_pkg::EV_CRC_ERR;
            end else begin
              r.kind = sfr_pkg::EV_OK;
            end
            m_crc = '0;
            m_phase = S_HUNT;
            emits = 1'b1;
          end
          default: begin
            m_phase = S_HUNT;
            if (b == sfr_pkg::BYTE_ACK) begin
              if (m_acks != 8'hFF) m_acks = m_acks + 8'd1;
              r.kind = sfr_pkg::EV_ACK;
              emits = 1'b1;
            end else if (b >= sfr_pkg::BYTE_START_MIN && b <= sfr_pkg::BYTE_START_MAX) begin
              m_prio = 2'(b - sfr_pkg::BYTE_START_MIN);
              m_crc = '0;
              m_phase = S_LEN;
            end else begin
              m_spur = sat_inc(m_spur);
              r.kind = sfr_pkg::EV_SPURIOUS;
              emits = 1'b1;
            end
          end
        endcase
      end
      sfr_pkg::CMD_TICK: begin
        if (m_phase != S_HUNT) begin
          n = int'(m_ticks) + 1;
          if (n > int'(m_limit)) begin
            m_ticks = '0;
            m_lost = sat_inc(m_lost);
            m_phase = S_HUNT;
            m_crc = '0;
            m_remaining = '0;
            r.kind = sfr_pkg::EV_LOST;
          end else begin
            m_ticks = 8'(n);
            r.kind = sfr_pkg::EV_BUSY;
          end
        end else begin
          m_ticks = '0;
          r.kind = sfr_pkg::EV_IDLE;
        end
        emits = 1'b1;
      end
      sfr_pkg::CMD_ACK_READ: begin
        r.acks = m_acks;
        m_acks = '0;
        r.kind = sfr_pkg::EV_ACK_READ;
        emits = 1'b1;
      end
      default: ;
    endcase
    if (emits) begin
      r.prio = m_prio;
      r.crc_err = m_bad;
      r.spurious = m_spur;
      r.lost = m_lost;
      if (c != sfr_pkg::CMD_ACK_READ) r.acks = m_acks;
      expected_events.push_back(r);
    end
  endtask

  // --------------------------------------------------------------------------
  // Channel drivers
  // --------------------------------------------------------------------------

  // Offers one input word at a falling edge, optionally after an idle burst,
  // and returns at the rising edge that accepts it. Valid stays high on
  // return, so the caller either sends the next word or lowers valid at the
  // next falling edge.
  task automatic send_word(input logic [1:0] c, input logic [7:0] b);
    int gap;
    gap = (gaps_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    byte_value <= b;
    do @(posedge clk); while (!in_ready);
    predict_events(c, b);
    words_sent++;
  endtask

  // Waits until every predicted result has arrived, then lets the pipeline
  // settle so that words which produce no result are also finished.
  task automatic wait_until_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == sfr_pkg::REG_CRC_POLY) m_poly = value;
    else m_limit = value[7:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Registers are only touched while the block is idle.
  task automatic configure(input logic [15:0] poly, input logic [7:0] limit);
    wait_until_quiet();
    write_register(sfr_pkg::REG_CRC_POLY, poly);
    write_register(sfr_pkg::REG_IDLE_LIMIT, {8'h00, limit});
  endtask

  // --------------------------------------------------------------------------
  // Stimulus building blocks
  // --------------------------------------------------------------------------

  // Noise injected between the bytes of a frame: ticks the frame survives,
  // acknowledge reads, unused commands, and now and then a run of ticks that
  // drops the frame so the rest of it is parsed as a broken sequence.
  task automatic line_disturbance();
    int pick;
    int n;
    pick = $urandom_range(0, 39);
    if (pick < 3 && m_limit != 8'd0) begin
      n = $urandom_range(1, (m_limit < 8'd4) ? int'(m_limit) : 4);
      repeat (n) send_word(sfr_pkg::CMD_TICK, 8'($urandom));
    end else if (pick == 3) begin
      send_word(sfr_pkg::CMD_ACK_READ, 8'($urandom));
    end else if (pick == 4) begin
      send_word(sfr_pkg::CMD_NONE, 8'($urandom));
    end else if (pick == 5 && m_limit < 8'd16) begin
      repeat (int'(m_limit) + 1) send_word(sfr_pkg::CMD_TICK, 8'($urandom));
    end
  endtask

  // Sends a whole frame with random payload. The trailer is the CRC of the
  // payload under the current polynomial, with one bit flipped if corrupt.
  task automatic send_frame(input logic [1:0] prio, input int len,
                            input bit long_form, input bit corrupt,
                            input bit noisy);
    logic [15:0] crc;
    logic [14:0] len_field;
    logic [7:0]  b;
    crc = 16'h0000;
    len_field = 15'(len);
    send_word(sfr_pkg::CMD_BYTE, sfr_pkg::BYTE_START_MIN + {6'd0, prio});
    if (long_form || len > 127) begin
      send_word(sfr_pkg::CMD_BYTE, {1'b1, len_field[14:8]});
      if (noisy) line_disturbance();
      send_word(sfr_pkg::CMD_BYTE, len_field[7:0]);
    end else begin
      send_word(sfr_pkg::CMD_BYTE, len_field[7:0]);
    end
    for (int i = 0; i < len; i++) begin
      if (noisy) line_disturbance();
      b = 8'($urandom);
      crc = crc16_fold_byte(crc, b, m_poly);
      send_word(sfr_pkg::CMD_BYTE, b);
    end
    if (corrupt) crc = crc ^ (16'd1 << $urandom_range(0, 15));
    send_word(sfr_pkg::CMD_BYTE, crc[15:8]);
    if (noisy) line_disturbance();
    send_word(sfr_pkg::CMD_BYTE, crc[7:0]);
  endtask

  // Any command with any byte, leaning toward the acknowledge byte.
  task automatic send_noise_word();
    logic [1:0] c;
    logic [7:0] b;
    c = 2'($urandom_range(0, 3));
    b = ($urandom_range(0, 3) == 0) ? sfr_pkg::BYTE_ACK : 8'($urandom);
    send_word(c, b);
  endtask

  // Mostly well-formed frames with random content, some corrupted, with
  // noise words and broken sequences in between. Most frames are short, a
  // few take the two-byte length.
  task automatic send_random_traffic(input int count);
    int goal;
    int len;
    goal = words_sent + count;
    while (words_sent < goal) begin
      if ($urandom_range(0, 9) < 7) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(128, 300)
                                           : $urandom_range(0, 12);
        send_frame(2'($urandom_range(0, 3)), len, $urandom_range(0, 3) == 0,
                   $urandom_range(0, 3) == 0, 1'b1);
      end else begin
        send_noise_word();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: every event kind, the extreme bytes, both length forms,
  // a zero length in each form, a bad CRC, and the largest length field
  // followed by a timeout that drops the frame.
  task automatic test_directed_frames();
    send_word(sfr_pkg::CMD_BYTE, 8'h00);
    send_word(sfr_pkg::CMD_BYTE, 8'hFF);
    send_word(sfr_pkg::CMD_BYTE, sfr_pkg::BYTE_ACK);
    send_word(sfr_pkg::CMD_TICK, 8'h00);
    send_word(sfr_pkg::CMD_NONE, 8'hA5);
    send_word(sfr_pkg::CMD_ACK_READ, 8'hFF);
    send_frame(2'd0, 0, 1'b0, 1'b0, 1'b0);
    send_frame(2'd2, 0, 1'b1, 1'b0, 1'b0);
    send_frame(2'd3, 1, 1'b1, 1'b1, 1'b0);
    send_word(sfr_pkg::CMD_BYTE, sfr_pkg::BYTE_START_MIN + 8'd1);
    send_word(sfr_pkg::CMD_BYTE, 8'hFF);
    send_word(sfr_pkg::CMD_BYTE, 8'hFF);
    send_word(sfr_pkg::CMD_BYTE, 8'h5A);
    repeat (int'(m_limit) + 1) send_word(sfr_pkg::CMD_TICK, 8'hFF);
  endtask

  // A limit of zero drops a frame on its first idle tick.
  task automatic test_zero_limit();
    configure(16'h0000, 8'd0);
    send_word(sfr_pkg::CMD_BYTE, sfr_pkg::BYTE_START_MIN);
    send_word(sfr_pkg::CMD_BYTE, 8'd5);
    send_word(sfr_pkg::CMD_BYTE, 8'h3C);
    send_word(sfr_pkg::CMD_TICK, 8'h00);
    send_random_traffic(150);
  endtask

  // The largest limit: 255 ticks are tolerated, the next one drops the frame.
  task automatic test_wide_limit();
    configure(16'hFFFF, 8'd255);
    send_word(sfr_pkg::CMD_BYTE, sfr_pkg::BYTE_START_MAX);
    send_word(sfr_pkg::CMD_BYTE, 8'd2);
    repeat (256) send_word(sfr_pkg::CMD_TICK, 8'($urandom));
    send_random_traffic(250);
  endtask

  task automatic test_random_settings();
    configure(16'h8005, 8'd1);
    send_random_traffic(350);
    configure(16'($urandom), 8'($urandom_range(1, 255)));
    send_random_traffic(300);
  endtask

  // The acknowledge count sticks at 255 until it is read.
  task automatic test_ack_saturation();
    send_word(sfr_pkg::CMD_ACK_READ, 8'h00);
    repeat (260) send_word(sfr_pkg::CMD_BYTE, sfr_pkg::BYTE_ACK);
    send_word(sfr_pkg::CMD_ACK_READ, 8'h00);
  endtask

  // The receiver holds off for a long stretch while words keep coming, so
  // the result register and the input register fill and in_ready drops.
  task automatic test_backpressure();
    hold_request = 1'b1;
    send_random_traffic(60);
  endtask

  // No idling on either side: back-to-back words at full rate.
  task automatic test_steady_stream();
    wait_until_quiet();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    configure(sfr_pkg::CRC_POLY_RESET, 8'd2);
    send_random_traffic(300);
  endtask

  // --------------------------------------------------------------------------
  // Result side: ready pattern, checking and watchdog
  // --------------------------------------------------------------------------

  // Random stall bursts, plus one long hold on request.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every accepted result word is matched against the oldest prediction.
  always @(posedge clk) begin : check_results
    sfr_pkg::result_t seen;
    sfr_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      seen = {event_kind, data_byte, frame_priority, ack_count,
              crc_error_count, spurious_count, lost_count};
      if (expected_events.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result word: kind %0d data %02h prio %0d acks %0d",
                   seen.kind, seen.data, seen.prio, seen.acks);
      end else begin
        want = expected_events.pop_front();
        if (seen.kind !== want.kind || seen.data !== want.data ||
            seen.prio !== want.prio || seen.acks !== want.acks ||
            seen.crc_err !== want.crc_err || seen.spurious !== want.spurious ||
            seen.lost !== want.lost) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("mismatch exp: kind %0d data %02h prio %0d acks %0d",
                     want.kind, want.data, want.prio, want.acks,
                     " crc %0d spur %0d lost %0d",
                     want.crc_err, want.spurious, want.lost);
            $display("         got: kind %0d data %02h prio %0d acks %0d",
                     seen.kind, seen.data, seen.prio, seen.acks,
                     " crc %0d spur %0d lost %0d",
                     seen.crc_err, seen.spurious, seen.lost);
          end
        end
      end
    end
  end

  // Ends a hung run: counts cycles in which no channel moves a word.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("serial_frame_receiver_tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    frame_model_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_frames();
    test_zero_limit();
    test_wide_limit();
    test_random_settings();
    test_ack_saturation();
    test_backpressure();
    test_steady_stream();

    wait_until_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    fail_count += expected_events.size();
    if (fail_count == 0) begin
      $display("serial_frame_receiver_tb passed");
    end else begin
      $display("serial_frame_receiver_tb failed");
    end
    $finish;
  end

endmodule
